@@ rtl/pmfp_pkg.sv @@
`default_nettype none
package pmfp_pkg;

  localparam int BYTE_W = 8;
  localparam int COEF_W = 24;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int DVD_W  = COEF_W + FRAC_W;
  localparam int QCNT_W = $clog2(DVD_W + 1);

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5A;

  localparam int DATA_BYTES = 21;
  localparam int CNT_W      = 5;
  localparam logic [CNT_W-1:0] CKSUM_POS = CNT_W'(DATA_BYTES);

  // byte offsets inside the data part of a frame
  localparam int OFS_VCOEF = 0;
  localparam int OFS_VCYC  = 3;
  localparam int OFS_ICOEF = 6;
  localparam int OFS_ICYC  = 9;
  localparam int OFS_PCOEF = 12;
  localparam int OFS_PCYC  = 15;
  localparam int OFS_ADJ   = 18;
  localparam int OFS_PULSE = 19;

  // adjust byte flags
  localparam int ADJ_V_BIT = 6;
  localparam int ADJ_I_BIT = 5;
  localparam int ADJ_P_BIT = 4;

  localparam logic [VAL_W-1:0] LIMIT_RESET   = 32'd950272;
  localparam logic [VAL_W-1:0] VOLTAGE_RESET = 32'd7864320;

  // channel index into the pending / updated masks
  localparam int NCH = 3;
  localparam logic [1:0] SEL_V = 2'd0;
  localparam logic [1:0] SEL_I = 2'd1;
  localparam logic [1:0] SEL_P = 2'd2;

  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] coef;
    logic [COEF_W-1:0] cycle;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/pmfp_if.sv @@
`default_nettype none
interface pmfp_byte_if;
  import pmfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pmfp_result_if;
  import pmfp_pkg::*;
  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [VAL_W-1:0] voltage;
  logic [VAL_W-1:0] current;
  logic [VAL_W-1:0] power;
  logic             voltage_updated;
  logic             current_updated;
  logic             power_updated;
  logic             overcurrent_trip;

  modport source (
    output valid, output frame_ok, output voltage, output current, output power,
    output voltage_updated, output current_updated, output power_updated,
    output overcurrent_trip, input ready
  );
  modport sink (
    input valid, input frame_ok, input voltage, input current, input power,
    input voltage_updated, input current_updated, input power_updated,
    input overcurrent_trip, output ready
  );
endinterface
`default_nettype wire

@@ rtl/pmfp_div.sv @@
`default_nettype none
module pmfp_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pmfp_pkg::div_req_t req,
  output pmfp_pkg::div_rsp_t      rsp
);
  import pmfp_pkg::*;

  logic              busy;
  logic              done;
  logic [QCNT_W-1:0] cnt;
  logic [COEF_W-1:0] rem;
  logic [DVD_W-1:0]  dq;
  logic [COEF_W-1:0] dvs;

  logic [COEF_W:0] trial;
  logic [COEF_W:0] diff;
  logic            fits;

  // restoring division, one quotient bit a cycle, quotient bits shift in behind the dividend
  assign trial = {rem, dq[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= QCNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - QCNT_W'(1);
        if (cnt == QCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= {req.coef, {FRAC_W{1'b0}}};
      dvs <= req.cycle;
    end else if (busy) begin
      rem <= fits ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

  // a zero divisor gives all ones, so it saturates along with any overflow
  assign rsp.done = done;
  assign rsp.quot = (|dq[DVD_W-1:VAL_W]) ? {VAL_W{1'b1}} : dq[VAL_W-1:0];

endmodule
`default_nettype wire

@@ rtl/power_meter_frame_parser.sv @@
`default_nettype none
// a rejected frame gives its result the cycle after the checksum byte is taken;
//   a good frame gives it after one quotient for each adjust bit set (0..3)
// throughput: one byte per cycle, the checksum byte waiting on an untaken result; none
//   while the quotients run on the one shared bit-serial divider (40 quotient bits)
// reset (synchronous, active high): parser back to the header hunt, limit to 14.5 A,
//   voltage to 120 V, current, power, coefficients and pulse count to zero
module power_meter_frame_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  pmfp_byte_if.sink                    rx,
  pmfp_result_if.source                res,
  input  wire logic                    cfg_we,
  input  wire logic [pmfp_pkg::VAL_W-1:0] cfg_wdata
);
  import pmfp_pkg::*;

  // top control: collecting bytes, or running the divisions of a good frame
  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  // header hunt and frame body
  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_SECOND = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] frame [DATA_BYTES];
  logic [BYTE_W-1:0] sum;

  logic [15:0]       last_pulse;
  logic [COEF_W-1:0] vcoef;
  logic [COEF_W-1:0] icoef;
  logic [COEF_W-1:0] pcoef;
  logic [VAL_W-1:0]  vval;
  logic [VAL_W-1:0]  ival;
  logic [VAL_W-1:0]  pval;
  logic [VAL_W-1:0]  limit;

  logic [NCH-1:0]    pend;
  logic [NCH-1:0]    upd;
  logic              trip;
  logic              div_run;
  logic [1:0]        cur;

  // result register, parts the divider side from the consumer
  logic              out_valid;
  logic              out_ok;
  logic [VAL_W-1:0]  out_v;
  logic [VAL_W-1:0]  out_i;
  logic [VAL_W-1:0]  out_p;
  logic [NCH-1:0]    out_upd;
  logic              out_trip;

  logic              rx_fire;
  logic              cksum_byte;
  logic              frame_good;
  logic [15:0]       pulse;
  logic [1:0]        pick;
  logic              load_out;

  div_req_t          dv_req;
  div_rsp_t          dv_rsp;

  // the checksum byte waits while an earlier result has not been taken yet
  assign cksum_byte = (phase == PH_BODY) && (byte_count == CKSUM_POS);
  assign rx.ready   = (state == ST_RECV) && !(out_valid && cksum_byte);
  assign rx_fire    = rx.valid && rx.ready;

  assign frame_good = (sum == rx.rx_byte);
  assign pulse      = {frame[OFS_PULSE], frame[OFS_PULSE+1]};

  // voltage goes to the divider first, then power, then current
  always_comb begin
    if (pend[SEL_V]) begin
      pick = SEL_V;
    end else if (pend[SEL_P]) begin
      pick = SEL_P;
    end else begin
      pick = SEL_I;
    end
  end

  always_comb begin
    dv_req.start = (state == ST_DIV) && !div_run && (|pend);
    unique case (pick)
      SEL_V: begin
        dv_req.coef  = vcoef;
        dv_req.cycle = {frame[OFS_VCYC], frame[OFS_VCYC+1], frame[OFS_VCYC+2]};
      end
      SEL_P: begin
        dv_req.coef  = pcoef;
        dv_req.cycle = {frame[OFS_PCYC], frame[OFS_PCYC+1], frame[OFS_PCYC+2]};
      end
      default: begin
        dv_req.coef  = icoef;
        dv_req.cycle = {frame[OFS_ICYC], frame[OFS_ICYC+1], frame[OFS_ICYC+2]};
      end
    endcase
  end

  pmfp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  assign load_out = (state == ST_DIV) && !div_run && (pend == '0);

  // data bytes shift through the frame line, oldest ends at the low end
  always_ff @(posedge clk) begin
    if (rx_fire && (phase == PH_SECOND)) begin
      sum <= '0;
    end else if (rx_fire && (phase == PH_BODY) && !cksum_byte) begin
      sum <= sum + rx.rx_byte;
      for (int k = 0; k < DATA_BYTES - 1; k++) begin
        frame[k] <= frame[k+1];
      end
      frame[DATA_BYTES-1] <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RECV;
      phase      <= PH_HUNT;
      byte_count <= '0;
      last_pulse <= '0;
      vcoef      <= '0;
      icoef      <= '0;
      pcoef      <= '0;
      vval       <= VOLTAGE_RESET;
      ival       <= '0;
      pval       <= '0;
      limit      <= LIMIT_RESET;
      pend       <= '0;
      upd        <= '0;
      trip       <= 1'b0;
      div_run    <= 1'b0;
      cur        <= SEL_V;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end

      // result transfer
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      if (rx_fire) begin
        unique case (phase)
          PH_HUNT: begin
            if (rx.rx_byte == HDR_FIRST) begin
              phase <= PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (rx.rx_byte == HDR_SECOND) begin
              phase      <= PH_BODY;
              byte_count <= '0;
            end else if (rx.rx_byte != HDR_FIRST) begin
              phase <= PH_HUNT;
            end
          end
          PH_BODY: begin
            if (cksum_byte) begin
              phase      <= PH_HUNT;
              byte_count <= '0;
              if (frame_good) begin
                // a new pulse count brings fresh coefficients
                if (pulse != last_pulse) begin
                  last_pulse <= pulse;
                  vcoef <= {frame[OFS_VCOEF], frame[OFS_VCOEF+1], frame[OFS_VCOEF+2]};
                  icoef <= {frame[OFS_ICOEF], frame[OFS_ICOEF+1], frame[OFS_ICOEF+2]};
                  pcoef <= {frame[OFS_PCOEF], frame[OFS_PCOEF+1], frame[OFS_PCOEF+2]};
                end
                pend[SEL_V] <= frame[OFS_ADJ][ADJ_V_BIT];
                pend[SEL_I] <= frame[OFS_ADJ][ADJ_I_BIT];
                pend[SEL_P] <= frame[OFS_ADJ][ADJ_P_BIT];
                upd[SEL_V]  <= frame[OFS_ADJ][ADJ_V_BIT];
                upd[SEL_I]  <= frame[OFS_ADJ][ADJ_I_BIT];
                upd[SEL_P]  <= frame[OFS_ADJ][ADJ_P_BIT];
                trip        <= 1'b0;
                state       <= ST_DIV;
              end else begin
                // rejected frame: held values, no flags
                out_valid <= 1'b1;
                out_ok    <= 1'b0;
                out_v     <= vval;
                out_i     <= ival;
                out_p     <= pval;
                out_upd   <= '0;
                out_trip  <= 1'b0;
              end
            end else begin
              byte_count <= byte_count + CNT_W'(1);
            end
          end
          default: begin
            phase <= PH_HUNT;
          end
        endcase
      end

      if (state == ST_DIV) begin
        if (div_run) begin
          if (dv_rsp.done) begin
            div_run   <= 1'b0;
            pend[cur] <= 1'b0;
            unique case (cur)
              SEL_V: vval <= dv_rsp.quot;
              SEL_P: pval <= dv_rsp.quot;
              default: begin
                ival <= dv_rsp.quot;
                trip <= (dv_rsp.quot > limit);
              end
            endcase
          end
        end else if (load_out) begin
          out_valid <= 1'b1;
          out_ok    <= 1'b1;
          out_v     <= vval;
          out_i     <= ival;
          out_p     <= pval;
          out_upd   <= upd;
          out_trip  <= trip;
          state     <= ST_RECV;
        end else begin
          div_run <= 1'b1;
          cur     <= pick;
        end
      end
    end
  end

  assign res.valid            = out_valid;
  assign res.frame_ok         = out_ok;
  assign res.voltage          = out_v;
  assign res.current          = out_i;
  assign res.power            = out_p;
  assign res.voltage_updated  = out_upd[SEL_V];
  assign res.current_updated  = out_upd[SEL_I];
  assign res.power_updated    = out_upd[SEL_P];
  assign res.overcurrent_trip = out_trip;

  // trip only ever comes with a fresh current
  a_trip_needs_current: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.overcurrent_trip |-> res.current_updated)
    else $error("trip without current update");

  // a rejected frame carries no update flags
  a_bad_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.frame_ok |->
      !(res.voltage_updated || res.current_updated || res.power_updated))
    else $error("update flag on rejected frame");

  // quotients only come back for a division this block started
  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    dv_rsp.done |-> (state == ST_DIV) && div_run)
    else $error("stray divider completion");

  // no byte is taken while the divider owns the frame line
  a_no_rx_in_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !rx_fire)
    else $error("byte taken during division");

endmodule
`default_nettype wire

@@ sim/tb_power_meter_frame_parser.sv @@
module tb_power_meter_frame_parser;
  import pmfp_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT      = 600000;
  localparam int DRAIN_CYCLES     = 160;     // longer than the worst good-frame latency
  // random traffic runs until this many bytes have gone in; the steady tail adds about 290
  localparam int TAIL_START_BYTES = 610;
  localparam int FRAME_LEN        = DATA_BYTES + 1;

  // adjust byte codes used by the directed frames
  localparam logic [BYTE_W-1:0] ADJ_NONE   = '0;
  localparam logic [BYTE_W-1:0] ADJ_ONLY_I = BYTE_W'(1 << ADJ_I_BIT);
  localparam logic [BYTE_W-1:0] ADJ_V_P    = BYTE_W'((1 << ADJ_V_BIT) | (1 << ADJ_P_BIT));
  localparam logic [BYTE_W-1:0] ADJ_ALL    =
    BYTE_W'((1 << ADJ_V_BIT) | (1 << ADJ_I_BIT) | (1 << ADJ_P_BIT));

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_FRAME} sync_state_t;

  // one meter reading as it leaves the block
  typedef struct packed {
    logic             frame_ok;
    logic [VAL_W-1:0] voltage;
    logic [VAL_W-1:0] current;
    logic [VAL_W-1:0] power;
    logic             v_upd;
    logic             i_upd;
    logic             p_upd;
    logic             trip;
  } reading_t;

  // contents of one frame before it is serialised
  typedef struct packed {
    logic [COEF_W-1:0] v_coef;
    logic [COEF_W-1:0] v_cycle;
    logic [COEF_W-1:0] i_coef;
    logic [COEF_W-1:0] i_cycle;
    logic [COEF_W-1:0] p_coef;
    logic [COEF_W-1:0] p_cycle;
    logic [BYTE_W-1:0] adjust;
    logic [15:0]       pulse;
  } frame_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [VAL_W-1:0]  cfg_wdata;

  pmfp_byte_if   rx_ch ();
  pmfp_result_if res_ch ();

  power_meter_frame_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------
  // meter predictor state: parser, frame bytes, coefficients, held values
  // ---------------------------------------------------------------
  sync_state_t       sync_state;
  int                frame_pos;
  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
  logic [15:0]       last_pulse;
  logic [COEF_W-1:0] v_coef_q, i_coef_q, p_coef_q;
  logic [VAL_W-1:0]  volt_q, curr_q, pow_q;
  logic [VAL_W-1:0]  limit_q;

  reading_t pending_readings [$];

  int  error_count      = 0;
  int  readings_seen    = 0;
  int  bytes_sent       = 0;
  int  cycle_count      = 0;
  bit  idle_on          = 1'b1;
  int  ready_hold       = 0;

  // ---------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // a hung handshake or a lost reading ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------
  task automatic reset_prediction();
    sync_state = HUNT_FIRST;
    frame_pos  = 0;
    last_pulse = '0;
    v_coef_q   = '0;
    i_coef_q   = '0;
    p_coef_q   = '0;
    volt_q     = VOLTAGE_RESET;
    curr_q     = '0;
    pow_q      = '0;
    limit_q    = LIMIT_RESET;
  endtask

  // unsigned Q16.16 quotient, saturating on a zero divisor or overflow
  function automatic logic [VAL_W-1:0] q16_quotient(input logic [COEF_W-1:0] coef,
                                                    input logic [COEF_W-1:0] cycle);
    logic [DVD_W-1:0] quot;
    if (cycle == '0) return '1;
    quot = {coef, {FRAC_W{1'b0}}} / DVD_W'(cycle);
    if (quot[DVD_W-1:VAL_W] != '0) return '1;
    return quot[VAL_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] field24(input int pos);
    return {frame_bytes[pos], frame_bytes[pos+1], frame_bytes[pos+2]};
  endfunction

  // advances the parser by one byte; returns 1 when a frame completes
  function automatic bit predict_meter_byte(input logic [BYTE_W-1:0] b, output reading_t r);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] adj;
    logic [15:0]       pulse;
    r = '0;
    case (sync_state)
      HUNT_FIRST: begin
        if (b == HDR_FIRST) sync_state = HUNT_SECOND;
        return 1'b0;
      end
      HUNT_SECOND: begin
        // a repeated first header byte keeps waiting for the second
        if (b == HDR_SECOND) sync_state = IN_FRAME;
        else if (b != HDR_FIRST) sync_state = HUNT_FIRST;
        return 1'b0;
      end
      default: ;
    endcase
    frame_bytes[frame_pos] = b;
    frame_pos++;
    if (frame_pos < FRAME_LEN) return 1'b0;

    sum = '0;
    for (int i = 0; i < DATA_BYTES; i++) sum += frame_bytes[i];
    r.frame_ok = (sum == frame_bytes[DATA_BYTES]);
    if (r.frame_ok) begin
      adj   = frame_bytes[OFS_ADJ];
      pulse = {frame_bytes[OFS_PULSE], frame_bytes[OFS_PULSE+1]};
      // coefficients only move when the pulse counter moves
      if (pulse != last_pulse) begin
        last_pulse = pulse;
        v_coef_q   = field24(OFS_VCOEF);
        i_coef_q   = field24(OFS_ICOEF);
        p_coef_q   = field24(OFS_PCOEF);
      end
      if (adj[ADJ_V_BIT]) begin
        volt_q  = q16_quotient(v_coef_q, field24(OFS_VCYC));
        r.v_upd = 1'b1;
      end
      if (adj[ADJ_P_BIT]) begin
        pow_q   = q16_quotient(p_coef_q, field24(OFS_PCYC));
        r.p_upd = 1'b1;
      end
      if (adj[ADJ_I_BIT]) begin
        curr_q  = q16_quotient(i_coef_q, field24(OFS_ICYC));
        r.i_upd = 1'b1;
        r.trip  = (curr_q > limit_q);
      end
    end
    r.voltage  = volt_q;
    r.current  = curr_q;
    r.power    = pow_q;
    sync_state = HUNT_FIRST;
    frame_pos  = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // byte sender
  // ---------------------------------------------------------------
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      rx_ch.valid <= 1'b0;
    end
  endtask

  // valid stays high after the transfer so that back-to-back bytes need no gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    reading_t r;
    if (idle_on && $urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 18));
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    bytes_sent++;
    if (predict_meter_byte(b, r)) pending_readings.push_back(r);
  endtask

  task automatic send_frame(input frame_t f, input bit bad_sum);
    logic [BYTE_W-1:0] data [DATA_BYTES];
    logic [BYTE_W-1:0] sum;
    {data[OFS_VCOEF], data[OFS_VCOEF+1], data[OFS_VCOEF+2]} = f.v_coef;
    {data[OFS_VCYC],  data[OFS_VCYC+1],  data[OFS_VCYC+2]}  = f.v_cycle;
    {data[OFS_ICOEF], data[OFS_ICOEF+1], data[OFS_ICOEF+2]} = f.i_coef;
    {data[OFS_ICYC],  data[OFS_ICYC+1],  data[OFS_ICYC+2]}  = f.i_cycle;
    {data[OFS_PCOEF], data[OFS_PCOEF+1], data[OFS_PCOEF+2]} = f.p_coef;
    {data[OFS_PCYC],  data[OFS_PCYC+1],  data[OFS_PCYC+2]}  = f.p_cycle;
    data[OFS_ADJ] = f.adjust;
    {data[OFS_PULSE], data[OFS_PULSE+1]} = f.pulse;
    sum = '0;
    foreach (data[i]) sum += data[i];
    // a corrupted checksum is always off by a non-zero amount
    if (bad_sum) sum += BYTE_W'($urandom_range(1, 255));
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    foreach (data[i]) send_byte(data[i]);
    send_byte(sum);
  endtask

  function automatic frame_t make_frame(
    input logic [COEF_W-1:0] v_coef, input logic [COEF_W-1:0] v_cycle,
    input logic [COEF_W-1:0] i_coef, input logic [COEF_W-1:0] i_cycle,
    input logic [COEF_W-1:0] p_coef, input logic [COEF_W-1:0] p_cycle,
    input logic [BYTE_W-1:0] adjust, input logic [15:0] pulse);
    frame_t f;
    f.v_coef  = v_coef;  f.v_cycle = v_cycle;
    f.i_coef  = i_coef;  f.i_cycle = i_cycle;
    f.p_coef  = p_coef;  f.p_cycle = p_cycle;
    f.adjust  = adjust;
    f.pulse   = pulse;
    return f;
  endfunction

  // ---------------------------------------------------------------
  // idle point and register write
  // ---------------------------------------------------------------
  // stop sending, let every reading arrive, then give the divider time to settle
  task automatic wait_for_idle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [VAL_W-1:0] value);
    wait_for_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_q = value;
  endtask

  // ---------------------------------------------------------------
  // result side: random back-pressure and checking
  // ---------------------------------------------------------------
  // ready drops in bursts while idling is on, and stays high otherwise
  always @(negedge clk) begin
    if (!idle_on) begin
      ready_hold = 0;
      res_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 17);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch at reading %0d: %s got %h wanted %h", readings_seen, what, got, want);
  endtask

  task automatic check_reading();
    reading_t want;
    readings_seen++;
    if (pending_readings.size() == 0) begin
      report_mismatch("unexpected reading, voltage", res_ch.voltage, '0);
      return;
    end
    want = pending_readings.pop_front();
    if (res_ch.frame_ok !== want.frame_ok)
      report_mismatch("frame_ok", VAL_W'(res_ch.frame_ok), VAL_W'(want.frame_ok));
    if (res_ch.voltage !== want.voltage)
      report_mismatch("voltage", res_ch.voltage, want.voltage);
    if (res_ch.current !== want.current)
      report_mismatch("current", res_ch.current, want.current);
    if (res_ch.power !== want.power)
      report_mismatch("power", res_ch.power, want.power);
    if (res_ch.voltage_updated !== want.v_upd)
      report_mismatch("voltage_updated", VAL_W'(res_ch.voltage_updated), VAL_W'(want.v_upd));
    if (res_ch.current_updated !== want.i_upd)
      report_mismatch("current_updated", VAL_W'(res_ch.current_updated), VAL_W'(want.i_upd));
    if (res_ch.power_updated !== want.p_upd)
      report_mismatch("power_updated", VAL_W'(res_ch.power_updated), VAL_W'(want.p_upd));
    if (res_ch.overcurrent_trip !== want.trip)
      report_mismatch("overcurrent_trip", VAL_W'(res_ch.overcurrent_trip), VAL_W'(want.trip));
  endtask

  // a reading counts at the rising edge where valid and ready are both high
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_reading();
  end

  // ---------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------
  // held values straight after reset, and a computed zero staying zero
  task automatic test_reset_readings();
    send_frame(make_frame(24'h0, 24'h1, 24'h0, 24'h1, 24'h0, 24'h1, ADJ_NONE, 16'h0), 1'b0);
    // pulse count equal to the reset one: coefficients stay zero, so all quotients are zero
    send_frame(make_frame(24'h123456, 24'h1, 24'h123456, 24'h1, 24'h123456, 24'h1,
                          ADJ_ALL, 16'h0), 1'b0);
    wait_for_idle();
  endtask

  // repeated first header, a broken header and stray second header bytes
  task automatic test_header_hunt();
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_frame(make_frame(24'h555A55, 24'h5A555A, 24'h0, 24'h5A, 24'h55, 24'h0,
                          ADJ_NONE, 16'h555A), 1'b0);
    send_byte(HDR_FIRST);
    send_byte(8'h00);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);
    send_frame(make_frame(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                          24'hFFFFFF, 8'hFF, 16'hFFFF), 1'b0);
    wait_for_idle();
  endtask

  // a rejected frame must change nothing, even with a new pulse count
  task automatic test_bad_checksum();
    send_frame(make_frame(24'h010000, 24'h000100, 24'h020000, 24'h000200, 24'h030000,
                          24'h000300, ADJ_ALL, 16'h0001), 1'b1);
    send_frame(make_frame(24'h010000, 24'h000100, 24'h020000, 24'h000200, 24'h030000,
                          24'h000300, ADJ_ALL, 16'h0001), 1'b0);
    send_frame(make_frame(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, ADJ_ALL, 16'h0002), 1'b1);
    wait_for_idle();
  endtask

  // zero divisor, quotient overflow, exact limits and stale coefficients
  task automatic test_quotient_edges();
    send_frame(make_frame(24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h1, 24'hFFFFFF, 24'hFFFFFF,
                          ADJ_ALL, 16'h0002), 1'b0);
    // same pulse count: the new coefficient fields are ignored
    send_frame(make_frame(24'h000001, 24'h000100, 24'h000001, 24'h0000FF, 24'h000001,
                          24'h000100, ADJ_ALL, 16'h0002), 1'b0);
    send_frame(make_frame(24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
                          24'hFFFFFF, ADJ_ALL, 16'hFFFF), 1'b0);
    send_frame(make_frame(24'h7FFFFF, 24'h000080, 24'h800000, 24'h000080, 24'h000000,
                          24'h0, ADJ_V_P, 16'h8000), 1'b0);
    wait_for_idle();
  endtask

  // trip is strictly greater than, and only on a current update
  task automatic test_trip_limit();
    write_limit(32'h0001_0000);
    send_frame(make_frame(24'h0, 24'h1, 24'd100, 24'd100, 24'h0, 24'h1, ADJ_ONLY_I, 16'h0003),
               1'b0);
    send_frame(make_frame(24'h0, 24'h1, 24'd101, 24'd100, 24'h0, 24'h1, ADJ_ONLY_I, 16'h0004),
               1'b0);
    send_frame(make_frame(24'h1, 24'h1, 24'hFFFFFF, 24'h1, 24'h1, 24'h1, ADJ_V_P, 16'h0005),
               1'b0);
    write_limit('0);
    send_frame(make_frame(24'h0, 24'h1, 24'h1, 24'hFFFFFF, 24'h0, 24'h1, ADJ_ONLY_I, 16'h0006),
               1'b0);
    send_frame(make_frame(24'h0, 24'h1, 24'h1, 24'h1, 24'h0, 24'h1, ADJ_ONLY_I, 16'h0007), 1'b0);
    write_limit('1);
    send_frame(make_frame(24'h0, 24'h1, 24'hFFFFFF, 24'h0, 24'h0, 24'h1, ADJ_ALL, 16'h0008),
               1'b0);
    write_limit(LIMIT_RESET);
  endtask

  // ---------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_W'($urandom_range(0, 255));
      1:       return COEF_W'(24'hFFFFFF - $urandom_range(0, 255));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // a zero divisor saturates, small ones can overflow, large ones give ordinary readings
  function automatic logic [COEF_W-1:0] pick_cycle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1, 2:    return COEF_W'($urandom_range(1, 255));
      3, 4, 5: return COEF_W'($urandom_range(256, 65535));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_RESET;
      3, 4:    return VAL_W'($urandom_range(0, 1 << 24));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic frame_t pick_frame();
    frame_t f;
    f.v_coef  = pick_coef();
    f.v_cycle = pick_cycle();
    f.i_coef  = pick_coef();
    f.i_cycle = pick_cycle();
    f.p_coef  = pick_coef();
    f.p_cycle = pick_cycle();
    f.adjust  = BYTE_W'($urandom);
    // half the frames repeat the pulse count so that stale coefficients get used
    f.pulse   = $urandom_range(0, 1) ? last_pulse : 16'($urandom);
    return f;
  endfunction

  // mostly well-formed frames, some rejected ones, line noise and cut-off frames
  task automatic test_random_traffic();
    int frames;
    frames = 0;
    while (bytes_sent < TAIL_START_BYTES) begin
      if (frames % 8 == 0) begin
        write_limit(pick_limit());
        idle_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 8)) send_byte(BYTE_W'($urandom));
        1: begin
          send_byte(HDR_FIRST);
          send_byte(HDR_SECOND);
          repeat ($urandom_range(1, DATA_BYTES - 1)) send_byte(BYTE_W'($urandom));
        end
        2, 3: send_frame(pick_frame(), 1'b1);
        default: send_frame(pick_frame(), 1'b0);
      endcase
      frames++;
    end
    wait_for_idle();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_tail();
    write_limit(pick_limit());
    idle_on = 1'b0;
    repeat (12) send_frame(pick_frame(), $urandom_range(0, 5) == 0);
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    reset_prediction();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_readings();
    test_header_hunt();
    test_bad_checksum();
    test_quotient_edges();
    test_trip_limit();
    test_random_traffic();
    test_steady_tail();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
